[hdl/tcw_pkg.sv]
// Shared constants and command codes for the text console writer.
`default_nettype none

package tcw_pkg;

  // Field widths of the command and result transactions
  localparam int MODE_W   = 3;
  localparam int CHAR_W   = 8;
  localparam int INADDR_W = 11;
  localparam int POS_W    = 11;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Character codes and attribute at reset
  localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'h08;
  localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h07;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_PUT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_UP    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DOWN  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd6;

endpackage

`default_nettype wire

[hdl/tcw_mem.sv]
// Screen cell memory: one write port, one read port with registered data.
`default_nettype none

module tcw_mem #(
  parameter int DEPTH  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ADDR_W-1:0]         waddr,
  input  wire logic [tcw_pkg::CELL_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]         raddr,
  output logic      [tcw_pkg::CELL_W-1:0] rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem_r [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rdata_r;

  // Write one cell
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hdl/tcw_ctrl.sv]
// Command sequencer: cursor, attribute, screen sweeps and the result register.
`default_nettype none

module tcw_ctrl #(
  parameter int COLUMNS    = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS       = tcw_pkg::DEF_ROWS,
  parameter int CELL_COUNT = COLUMNS * ROWS,
  parameter int ADDR_W     = $clog2(CELL_COUNT)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tcw_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic [tcw_pkg::INADDR_W-1:0]  in_cell_address,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [tcw_pkg::POS_W-1:0]     out_cursor_position,
  output logic      [tcw_pkg::CELL_W-1:0]    out_cell_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tcw_pkg::ATTR_W-1:0]    cfg_wr_data,
  output logic                               mem_we,
  output logic      [ADDR_W-1:0]             mem_waddr,
  output logic      [tcw_pkg::CELL_W-1:0]    mem_wdata,
  output logic      [ADDR_W-1:0]             mem_raddr,
  input  wire logic [tcw_pkg::CELL_W-1:0]    mem_rdata
);

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLUMNS);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_FIN, S_READ} state_t;
  typedef enum logic [1:0] {K_INIT, K_CLEAR, K_SCROLL} kind_t;

  state_t                      state_r, state_nxt;
  kind_t                       kind_r, kind_nxt;
  logic [ADDR_W-1:0]           cnt_r, cnt_nxt;
  logic [ROW_W-1:0]            row_r, row_nxt;
  logic [COL_W-1:0]            col_r, col_nxt;
  logic [tcw_pkg::ATTR_W-1:0]  attr_r, attr_nxt;
  logic                        stg_v_r, stg_v_nxt;
  logic [ADDR_W-1:0]           stg_addr_r, stg_addr_nxt;
  logic                        stg_rd_r, stg_rd_nxt;
  logic [tcw_pkg::CELL_W-1:0]  stg_data_r, stg_data_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [tcw_pkg::POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [tcw_pkg::CELL_W-1:0]  out_data_r, out_data_nxt;

  logic                        out_free;
  logic                        accept;
  logic                        row_last;
  logic                        col_last;
  logic                        addr_ok;
  logic [ADDR_W-1:0]           pos_cur;
  logic [tcw_pkg::CELL_W-1:0]  blank_cell;
  logic                        ld;
  logic [tcw_pkg::CELL_W-1:0]  ld_data;

  // Handshake and cursor-derived terms
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == S_IDLE) && out_free);
  assign accept     = in_valid && !in_stall;
  assign row_last   = (row_r == ROW_W'(ROWS - 1));
  assign col_last   = (col_r == COL_W'(COLUMNS - 1));
  assign addr_ok    = (32'(in_cell_address) < 32'(CELL_COUNT));
  assign pos_cur    = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign blank_cell = {attr_r, tcw_pkg::BLANK_CHAR};

  // Next-state logic
  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    cnt_nxt      = cnt_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    attr_nxt     = cfg_wr_en ? cfg_wr_data : attr_r;
    stg_v_nxt    = 1'b0;
    stg_addr_nxt = stg_addr_r;
    stg_rd_nxt   = 1'b0;
    stg_data_nxt = stg_data_r;
    ld           = 1'b0;
    ld_data      = '0;

    // Drain the sweep write stage by default
    mem_we    = stg_v_r;
    mem_waddr = stg_addr_r;
    mem_wdata = stg_rd_r ? mem_rdata : stg_data_r;
    mem_raddr = ADDR_W'(in_cell_address);

    case (state_r)
      S_SWEEP: begin
        // Issue one cell per cycle into the write stage
        stg_v_nxt    = 1'b1;
        stg_addr_nxt = cnt_r;
        stg_data_nxt = (kind_r == K_INIT) ? {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR}
                                          : blank_cell;
        if (kind_r == K_SCROLL && cnt_r < ADDR_W'(CELL_COUNT - COLUMNS)) begin
          mem_raddr  = cnt_r + ADDR_W'(COLUMNS);
          stg_rd_nxt = 1'b1;
        end
        cnt_nxt = cnt_r + ADDR_W'(1);
        if (cnt_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Last stage write lands now; report the command if any
        ld        = (kind_r != K_INIT);
        state_nxt = S_IDLE;
      end
      S_READ: begin
        ld        = 1'b1;
        ld_data   = mem_rdata;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          ld = 1'b1;
          case (in_mode)
            tcw_pkg::MODE_PUT: begin
              if (in_char_code == tcw_pkg::NEWLINE_CHAR) begin
                col_nxt = '0;
                if (row_last) begin
                  ld        = 1'b0;
                  kind_nxt  = K_SCROLL;
                  cnt_nxt   = '0;
                  state_nxt = S_SWEEP;
                end else begin
                  row_nxt = row_r + ROW_W'(1);
                end
              end else if (in_char_code == tcw_pkg::BACKSPACE_CHAR) begin
                if (col_r != '0) begin
                  col_nxt   = col_r - COL_W'(1);
                  mem_we    = 1'b1;
                  mem_waddr = pos_cur - ADDR_W'(1);
                  mem_wdata = blank_cell;
                end
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pos_cur;
                mem_wdata = {attr_r, in_char_code};
                if (col_last) begin
                  col_nxt = '0;
                  if (row_last) begin
                    ld        = 1'b0;
                    kind_nxt  = K_SCROLL;
                    cnt_nxt   = '0;
                    state_nxt = S_SWEEP;
                  end else begin
                    row_nxt = row_r + ROW_W'(1);
                  end
                end else begin
                  col_nxt = col_r + COL_W'(1);
                end
              end
            end
            tcw_pkg::MODE_CLEAR: begin
              ld        = 1'b0;
              row_nxt   = '0;
              col_nxt   = '0;
              kind_nxt  = K_CLEAR;
              cnt_nxt   = '0;
              state_nxt = S_SWEEP;
            end
            tcw_pkg::MODE_LEFT: begin
              if (col_r != '0) begin
                col_nxt = col_r - COL_W'(1);
              end
            end
            tcw_pkg::MODE_RIGHT: begin
              if (!col_last) begin
                col_nxt = col_r + COL_W'(1);
              end
            end
            tcw_pkg::MODE_UP: begin
              if (row_r != '0) begin
                row_nxt = row_r - ROW_W'(1);
              end
            end
            tcw_pkg::MODE_DOWN: begin
              if (!row_last) begin
                row_nxt = row_r + ROW_W'(1);
              end
            end
            tcw_pkg::MODE_READ: begin
              if (addr_ok) begin
                ld        = 1'b0;
                state_nxt = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Result register: load a finished command, drop a taken transaction
    out_valid_nxt = out_valid_r && out_stall;
    out_pos_nxt   = out_pos_r;
    out_data_nxt  = out_data_r;
    if (ld) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = tcw_pkg::POS_W'(ADDR_W'(row_nxt) * ADDR_W'(COLUMNS) + ADDR_W'(col_nxt));
      out_data_nxt  = ld_data;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      kind_r      <= K_INIT;
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      attr_r      <= tcw_pkg::RESET_ATTR;
      stg_v_r     <= 1'b0;
      stg_rd_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      cnt_r       <= cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      attr_r      <= attr_nxt;
      stg_v_r     <= stg_v_nxt;
      stg_rd_r    <= stg_rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    stg_addr_r <= stg_addr_nxt;
    stg_data_r <= stg_data_nxt;
    out_pos_r  <= out_pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_pos_r;
  assign out_cell_data       = out_data_r;

endmodule

`default_nettype wire

[hdl/text_console_writer_unit.sv]
// Top level of the text console writer: sequencer plus screen cell memory.
//
// Text console: a COLUMNS x ROWS screen of 16-bit cells (attribute high byte,
// character low byte) kept in one on-chip memory, plus a cursor. Moves, reads
// outside the screen, and puts that need no scroll take one command per cycle
// while the result is not stalled; a read inside the screen holds the command
// input for its registered memory read. Clear and scroll walk the whole memory
// one cell a cycle through its single write port and stall the command input
// until the sweep and its last write are done. After reset a clearing pass
// fills the screen with blanks in attribute 0x07 before the first command is
// taken; attribute writes are taken at any time. A new command is taken at the
// edge at which the previous result is taken, so a stalled result stalls the
// command input as well.
`default_nettype none

module text_console_writer_unit #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tcw_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic [tcw_pkg::INADDR_W-1:0]  in_cell_address,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [tcw_pkg::POS_W-1:0]     out_cursor_position,
  output logic      [tcw_pkg::CELL_W-1:0]    out_cell_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tcw_pkg::ATTR_W-1:0]    cfg_wr_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]          mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  // Command sequencer
  tcw_ctrl #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .CELL_COUNT (CELL_COUNT),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_char_code        (in_char_code),
    .in_cell_address     (in_cell_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cursor_position (out_cursor_position),
    .out_cell_data       (out_cell_data),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .mem_we              (mem_we),
    .mem_waddr           (mem_waddr),
    .mem_wdata           (mem_wdata),
    .mem_raddr           (mem_raddr),
    .mem_rdata           (mem_rdata)
  );

  // Screen cell memory
  tcw_mem #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
